/* rtl/prd_pkg.sv */
// pulse rate detector package: constants, register indexes, fsm states,
// controller/datapath command and status structs. no dependencies.
`timescale 1ns / 1ps
package prd_pkg;

	localparam int BASELINE_DEPTH_DEF = 50;

	localparam int SAMPLE_W = 12;
	localparam int TIME_W   = 32;
	localparam int RATE_W   = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int TALLY_W  = 16;
	localparam int DIV_W    = 32;

	localparam logic [15:0] CAL_MS_RST    = 16'd10000;
	localparam logic [11:0] MIN_DEV_RST   = 12'd50;
	localparam logic [11:0] MIN_RANGE_RST = 12'd20;
	localparam logic [7:0]  MIN_RATE_RST  = 8'd40;
	localparam logic [7:0]  MAX_RATE_RST  = 8'd180;
	localparam logic [15:0] WINDOW_MS_RST = 16'd5000;

	localparam logic [11:0] WIN_MIN_INIT = 12'd4000;
	localparam logic [11:0] THR_KNEE     = 12'd40;
	localparam logic [11:0] THR_FLOOR    = 12'd10;
	localparam logic [4:0]  RUN_LIMIT    = 5'd20;
	localparam logic [31:0] MS_PER_MIN   = 32'd60000;
	localparam logic [15:0] MIN_INTERVALS = 16'd4;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CAL_MS    = 3'd0,
		REG_MIN_DEV   = 3'd1,
		REG_MIN_RANGE = 3'd2,
		REG_MIN_RATE  = 3'd3,
		REG_MAX_RATE  = 3'd4,
		REG_WINDOW_MS = 3'd5
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_FILL,
		ST_BASE,
		ST_BEAT,
		ST_AVG,
		ST_CALC,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic load;
		logic eval;
		logic fill;
		logic base;
		logic beat;
		logic avg;
		logic calc;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic calibrated;
		logic cal_end;
		logic go_base;
		logic fill_last;
		logic div_done;
		logic win_end;
		logic tally_ok;
		logic avg_nz;
		logic out_busy;
	} sts_t;

	typedef struct packed {
		logic              calibrating;
		logic              finger_present;
		logic              beat;
		logic              window_closed;
		logic [RATE_W-1:0] rate_latest;
		logic [RATE_W-1:0] rate_reported;
	} res_t;

endpackage

/* rtl/prd_if.sv */
// channel interfaces of the pulse rate detector: sample, result, config write.
// depends on prd_pkg.
`timescale 1ns / 1ps
interface prd_smp_if;
	import prd_pkg::*;
	logic                valid;
	logic                ready;
	logic [SAMPLE_W-1:0] sample_mv;
	logic [TIME_W-1:0]   time_ms;
	modport source (output valid, sample_mv, time_ms, input ready);
	modport sink (input valid, sample_mv, time_ms, output ready);
endinterface

interface prd_res_if;
	import prd_pkg::*;
	logic              valid;
	logic              ready;
	logic              calibrating;
	logic              finger_present;
	logic              beat;
	logic              window_closed;
	logic [RATE_W-1:0] rate_latest;
	logic [RATE_W-1:0] rate_reported;
	modport source (output valid, calibrating, finger_present, beat, window_closed,
		rate_latest, rate_reported, input ready);
	modport sink (input valid, calibrating, finger_present, beat, window_closed,
		rate_latest, rate_reported, output ready);
endinterface

interface prd_cfg_if;
	import prd_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* rtl/prd_div.sv */
// iterative restoring divider, one quotient bit per cycle.
// depends on prd_pkg.
`timescale 1ns / 1ps
module prd_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [prd_pkg::DIV_W-1:0] dividend,
	input  logic [prd_pkg::DIV_W-1:0] divisor,
	output logic                      done,
	output logic [prd_pkg::DIV_W-1:0] quotient
);
	import prd_pkg::*;

	localparam int CNT_W = $clog2(DIV_W + 1);

	logic [DIV_W:0]   rem_q;
	logic [DIV_W-1:0] quo_q;
	logic [DIV_W-1:0] dvs_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DIV_W:0]   rem_sh;
	logic             take;

	assign rem_sh = {rem_q[DIV_W-1:0], quo_q[DIV_W-1]};
	assign take   = rem_sh >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIV_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= take ? rem_sh - {1'b0, dvs_q} : rem_sh;
			quo_q <= {quo_q[DIV_W-2:0], take};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;
endmodule

/* rtl/prd_dp.sv */
// pulse rate detector datapath: config registers, detector state, baseline
// ring memory, shared divider and result register. depends on prd_pkg, prd_div.
`timescale 1ns / 1ps
module prd_dp #(
	parameter int BASELINE_DEPTH = prd_pkg::BASELINE_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [prd_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [prd_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic [prd_pkg::SAMPLE_W-1:0]   in_sample,
	input  logic [prd_pkg::TIME_W-1:0]     in_time,
	input  logic                           out_ready,
	input  prd_pkg::cmd_t                  cmd,
	output prd_pkg::sts_t                  sts,
	output logic                           out_valid,
	output prd_pkg::res_t                  res
);
	import prd_pkg::*;

	localparam int AW    = $clog2(BASELINE_DEPTH);
	localparam int SUM_W = SAMPLE_W + AW;

	// baseline average by reciprocal multiplication, exact for sums below 2^SUM_W
	localparam int REC_SH = SUM_W + AW;
	localparam int REC_W  = SUM_W + 2;
	localparam int PRD_W  = SUM_W + REC_W;
	localparam logic [REC_W-1:0] REC_M = REC_W'(((64'd1 << REC_SH)
		+ 64'(BASELINE_DEPTH) - 64'd1) / 64'(BASELINE_DEPTH));

	// configuration
	logic [15:0] cal_ms_q, window_ms_q;
	logic [11:0] min_dev_q, min_range_q;
	logic [7:0]  min_rate_q, max_rate_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_ms_q    <= CAL_MS_RST;
			min_dev_q   <= MIN_DEV_RST;
			min_range_q <= MIN_RANGE_RST;
			min_rate_q  <= MIN_RATE_RST;
			max_rate_q  <= MAX_RATE_RST;
			window_ms_q <= WINDOW_MS_RST;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_idx))
				REG_CAL_MS:    cal_ms_q    <= cfg_data;
				REG_MIN_DEV:   min_dev_q   <= cfg_data[11:0];
				REG_MIN_RANGE: min_range_q <= cfg_data[11:0];
				REG_MIN_RATE:  min_rate_q  <= cfg_data[7:0];
				REG_MAX_RATE:  max_rate_q  <= cfg_data[7:0];
				REG_WINDOW_MS: window_ms_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// item capture
	logic [SAMPLE_W-1:0] v_q;
	logic [TIME_W-1:0]   t_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			v_q <= in_sample;
			t_q <= in_time;
		end
	end

	// detector state
	logic              calibrated_q, finger_q, above_q;
	logic [31:0]       cal_start_q, last_beat_q, total_q, wb_q;
	logic [11:0]       amb_q, wmin_q, wmax_q, thr_q;
	logic [AW-1:0]     pos_q, fill_q;
	logic [SUM_W-1:0]  sum_q;
	logic [4:0]        run_q;
	logic [TALLY_W-1:0] tally_q;
	logic [RATE_W-1:0] rate_q;
	logic              beat_q, closed_q, rise_q, had_last_q;
	logic [31:0]       iv_q;
	logic [11:0]       rd_q;

	logic [11:0] ring_mem [BASELINE_DEPTH];

	// divider
	logic        div_start, div_done;
	logic [31:0] div_a, div_b, div_quo;

	prd_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_a),
		.divisor  (div_b),
		.done     (div_done),
		.quotient (div_quo)
	);

	// calibration step
	logic [11:0] amb_eff, amb_n;
	logic [31:0] start_eff;
	logic        cal_end;

	always_comb begin
		amb_eff   = (cal_start_q == '0) ? v_q : amb_q;
		start_eff = (cal_start_q == '0) ? t_q : cal_start_q;
		amb_n     = (v_q < amb_eff) ? v_q : amb_eff;
		cal_end   = (t_q - start_eff) >= {16'd0, cal_ms_q};
	end

	// detection front
	logic [11:0]      dev, nmin, nmax, range, thr_n;
	logic             finger_ok, low_range, run_stop;
	logic [4:0]       run_n;
	logic [SUM_W-1:0] sum_n;
	logic [AW-1:0]    pos_n;

	always_comb begin
		dev       = (v_q >= amb_q) ? v_q - amb_q : amb_q - v_q;
		finger_ok = dev >= min_dev_q;
		sum_n     = sum_q - SUM_W'(rd_q) + SUM_W'(v_q);
		pos_n     = (pos_q == AW'(BASELINE_DEPTH - 1)) ? '0 : pos_q + 1'b1;
		nmin      = (v_q < wmin_q) ? v_q : wmin_q;
		nmax      = (v_q > wmax_q) ? v_q : wmax_q;
		range     = (nmax >= nmin) ? nmax - nmin : '0;
		low_range = range < min_range_q;
		run_n     = run_q + 1'b1;
		run_stop  = low_range && (run_n > RUN_LIMIT);
		thr_n     = (range > THR_KNEE) ? {2'b00, range[11:2]} : THR_FLOOR;
	end

	// baseline from the updated ring sum
	logic [PRD_W-1:0]    base_prod;
	logic [SAMPLE_W-1:0] base_mv;

	assign base_prod = PRD_W'(sum_q) * PRD_W'(REC_M);
	assign base_mv   = base_prod[REC_SH +: SAMPLE_W];

	// crossing and interval checks
	logic        cur;
	logic [7:0]  nz_min, nz_max;
	logic [40:0] p_lo;
	logic [39:0] p_hi;
	logic        iv_ok, beat_n, win_end, tally_ok;
	logic [31:0] total_n;
	logic [TALLY_W-1:0] tally_n;
	logic [RATE_W-1:0]  calc_r;

	always_comb begin
		cur     = {1'b0, v_q} > ({1'b0, base_mv} + {1'b0, thr_q});
		nz_min  = (min_rate_q == '0) ? 8'd1 : min_rate_q;
		nz_max  = (max_rate_q == '0) ? 8'd1 : max_rate_q;
		p_lo    = ({1'b0, iv_q} + 33'd1) * nz_max;
		p_hi    = iv_q * nz_min;
		iv_ok   = (p_lo > 41'(MS_PER_MIN)) && (p_hi <= 40'(MS_PER_MIN));
		beat_n  = rise_q && had_last_q && iv_ok;
		total_n = beat_n ? total_q + iv_q : total_q;
		tally_n = beat_n ? tally_q + 1'b1 : tally_q;
		win_end = (t_q - wb_q) >= {16'd0, window_ms_q};
		tally_ok = tally_n >= MIN_INTERVALS;
		calc_r  = ((div_quo >= {24'd0, min_rate_q}) && (div_quo <= {24'd0, max_rate_q}))
			? div_quo[RATE_W-1:0] : '0;
	end

	logic start_avg, start_calc;

	always_comb begin
		start_avg  = cmd.beat && win_end && tally_ok;
		start_calc = cmd.avg && (div_quo != '0);
		div_start  = start_avg || start_calc;
		if (start_avg) begin
			div_a = total_n;
			div_b = {16'd0, tally_n};
		end else begin
			div_a = MS_PER_MIN;
			div_b = div_quo;
		end
	end

	// ring memory
	logic          ring_we;
	logic [AW-1:0] ring_wa;

	assign ring_we = cmd.fill || (cmd.eval && calibrated_q && finger_ok);
	assign ring_wa = cmd.fill ? fill_q : pos_q;

	always_ff @(posedge clk) begin
		if (ring_we)
			ring_mem[ring_wa] <= v_q;
		rd_q <= ring_mem[pos_q];
	end

	// window close, with the rate to store
	logic             close;
	logic [RATE_W-1:0] close_r;

	always_comb begin
		close   = (cmd.beat && win_end && !tally_ok) || (cmd.avg && div_quo == '0)
			|| cmd.calc;
		close_r = cmd.calc ? calc_r : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			calibrated_q <= 1'b0;
			cal_start_q  <= '0;
			amb_q        <= '0;
			pos_q        <= '0;
			fill_q       <= '0;
			sum_q        <= '0;
			wmin_q       <= WIN_MIN_INIT;
			wmax_q       <= '0;
			run_q        <= '0;
			above_q      <= 1'b0;
			last_beat_q  <= '0;
			total_q      <= '0;
			tally_q      <= '0;
			wb_q         <= '0;
			rate_q       <= '0;
			finger_q     <= 1'b0;
			beat_q       <= 1'b0;
			closed_q     <= 1'b0;
			rise_q       <= 1'b0;
			had_last_q   <= 1'b0;
			thr_q        <= '0;
			iv_q         <= '0;
		end else begin
			if (cmd.load) begin
				beat_q   <= 1'b0;
				closed_q <= 1'b0;
			end
			if (cmd.eval && !calibrated_q) begin
				cal_start_q <= start_eff;
				amb_q       <= amb_n;
				if (cal_end) begin
					calibrated_q <= 1'b1;
					wmin_q       <= v_q;
					wmax_q       <= v_q;
					sum_q        <= SUM_W'(v_q) * SUM_W'(BASELINE_DEPTH);
					fill_q       <= '0;
				end
			end
			if (cmd.eval && calibrated_q) begin
				if (!finger_ok) begin
					finger_q <= 1'b0;
					rate_q   <= '0;
				end else begin
					finger_q <= !run_stop;
					if (wb_q == '0)
						wb_q <= t_q;
					sum_q  <= sum_n;
					pos_q  <= pos_n;
					wmin_q <= nmin;
					wmax_q <= nmax;
					thr_q  <= thr_n;
					if (low_range)
						run_q <= run_stop ? '0 : run_n;
				end
			end
			if (cmd.fill)
				fill_q <= fill_q + 1'b1;
			if (cmd.base) begin
				rise_q     <= cur && !above_q;
				had_last_q <= last_beat_q != '0;
				iv_q       <= t_q - last_beat_q;
				above_q    <= cur;
				if (cur && !above_q)
					last_beat_q <= t_q;
			end
			if (cmd.beat) begin
				beat_q  <= beat_n;
				total_q <= total_n;
				tally_q <= tally_n;
			end
			if (close) begin
				rate_q   <= close_r;
				total_q  <= '0;
				tally_q  <= '0;
				wb_q     <= t_q;
				wmin_q   <= WIN_MIN_INIT;
				wmax_q   <= '0;
				closed_q <= 1'b1;
			end
		end
	end

	// result register
	logic out_valid_q;
	res_t res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			res_q.calibrating    <= !calibrated_q;
			res_q.finger_present <= finger_q;
			res_q.beat           <= beat_q;
			res_q.window_closed  <= closed_q;
			res_q.rate_latest    <= rate_q;
			res_q.rate_reported  <= ((t_q - wb_q) > {15'd0, window_ms_q, 1'b0}) ? '0 : rate_q;
		end
	end

	assign out_valid = out_valid_q;
	assign res       = res_q;

	always_comb begin
		sts.calibrated = calibrated_q;
		sts.cal_end    = cal_end;
		sts.go_base    = finger_ok && !run_stop;
		sts.fill_last  = fill_q == AW'(BASELINE_DEPTH - 1);
		sts.div_done   = div_done;
		sts.win_end    = win_end;
		sts.tally_ok   = tally_ok;
		sts.avg_nz     = div_quo != '0;
		sts.out_busy   = out_valid_q && !out_ready;
	end
endmodule

/* rtl/prd_ctrl.sv */
// pulse rate detector controller: sequences one item through the datapath.
// depends on prd_pkg.
`timescale 1ns / 1ps
module prd_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  prd_pkg::sts_t sts,
	output prd_pkg::cmd_t cmd
);
	import prd_pkg::*;

	state_t state_q, state_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_n;
	end

	always_comb begin
		state_n = state_q;
		case (state_q)
			ST_IDLE: if (in_valid) state_n = ST_EVAL;
			ST_EVAL: begin
				if (!sts.calibrated)
					state_n = sts.cal_end ? ST_FILL : ST_FIN;
				else
					state_n = sts.go_base ? ST_BASE : ST_FIN;
			end
			ST_FILL: if (sts.fill_last) state_n = ST_FIN;
			ST_BASE: state_n = ST_BEAT;
			ST_BEAT: state_n = (sts.win_end && sts.tally_ok) ? ST_AVG : ST_FIN;
			ST_AVG: if (sts.div_done) state_n = sts.avg_nz ? ST_CALC : ST_FIN;
			ST_CALC: if (sts.div_done) state_n = ST_FIN;
			ST_FIN: if (!sts.out_busy) state_n = ST_IDLE;
			default: state_n = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_EVAL: cmd.eval = 1'b1;
			ST_FILL: cmd.fill = 1'b1;
			ST_BASE: cmd.base = 1'b1;
			ST_BEAT: cmd.beat = 1'b1;
			ST_AVG:  cmd.avg  = sts.div_done;
			ST_CALC: cmd.calc = sts.div_done;
			ST_FIN:  cmd.out_load = !sts.out_busy;
			default: ;
		endcase
	end
endmodule

/* rtl/pulse_rate_detector.sv */
// pulse rate detector top level: channel wiring of controller and datapath.
// depends on prd_pkg, prd_if, prd_ctrl, prd_dp.
//
// usage: samples (sample_mv, time_ms) enter on smp, one result item per
// sample leaves on res, register writes come in on cfg (always ready, index
// beyond the register list ignored). write registers only while idle.
// smp is ready in the idle state; an accepted item then passes through these states:
//   calibration sample, no finger or low-range stop: eval and fin, plus
//   a fill sweep on the sample that ends calibration (the baseline
//   ring is swept, one entry a cycle, over all BASELINE_DEPTH entries)
//   detection: eval, base, beat and fin; a window close with four or more intervals
//   adds the average interval division, and then the rate division
//   when that average is nonzero
// res turns valid in the cycle right after fin loads the result, the same cycle in
// which the next sample can be accepted.
// the result register lets the next sample be taken while a result waits;
// if res stalls, the following item halts before its own result is written.
// reset clears all detector state and loads the register defaults; the
// baseline ring needs no clearing since it is filled before first use.
`timescale 1ns / 1ps
module pulse_rate_detector #(
	parameter int BASELINE_DEPTH = prd_pkg::BASELINE_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	prd_smp_if.sink   smp,
	prd_res_if.source res,
	prd_cfg_if.sink   cfg
);
	import prd_pkg::*;

	cmd_t cmd;
	sts_t sts;
	res_t res_d;

	assign cfg.ready = 1'b1;

	prd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (smp.valid),
		.in_ready (smp.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	prd_dp #(
		.BASELINE_DEPTH (BASELINE_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg.valid),
		.cfg_idx   (cfg.index),
		.cfg_data  (cfg.data),
		.in_sample (smp.sample_mv),
		.in_time   (smp.time_ms),
		.out_ready (res.ready),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (res.valid),
		.res       (res_d)
	);

	assign res.calibrating    = res_d.calibrating;
	assign res.finger_present = res_d.finger_present;
	assign res.beat           = res_d.beat;
	assign res.window_closed  = res_d.window_closed;
	assign res.rate_latest    = res_d.rate_latest;
	assign res.rate_reported  = res_d.rate_reported;
endmodule
